@@ src/clus_pkg.sv @@
// Shared types and constants for the unstable log store.
`timescale 1ns / 1ps

package clus_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_APPEND      = 3'd0,
        OP_STABLE      = 3'd1,
        OP_STABLE_SNAP = 3'd2,
        OP_RESTORE     = 3'd3,
        OP_TERM        = 3'd4,
        OP_READ        = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DROP = 2'd2
    } t_status;

    typedef enum logic {
        S_CALC = 1'b0,
        S_EXEC = 1'b1
    } t_back_state;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] index;
        logic [63:0] term;
        logic [63:0] data;
        logic [63:0] range_end;
    } t_req_word;

    typedef struct packed {
        t_status     status;
        logic [63:0] term_out;
        logic [63:0] data_out;
        logic        has_first;
        logic [63:0] first_out;
        logic        has_last;
        logic [63:0] last_out;
        logic        has_snapshot;
        logic [63:0] snapshot_index_out;
        logic [63:0] snapshot_term_out;
    } t_rsp_word;

    // Decoded command as held in the queue.
    typedef struct packed {
        logic        known;
        t_op         op;
        logic [63:0] index;
        logic [63:0] term;
        logic [63:0] data;
        logic [63:0] range_end;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_head;

endpackage

@@ src/clus_if.sv @@
// Valid/ready channel interfaces for request and response words.
`timescale 1ns / 1ps

interface clus_req_if import clus_pkg::*; ();
    logic      valid;
    logic      ready;
    t_req_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface clus_rsp_if import clus_pkg::*; ();
    logic      valid;
    logic      ready;
    t_rsp_word word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

@@ src/clus_front.sv @@
// Front end: accepts request words, decodes the operation and queues them.
`timescale 1ns / 1ps

module clus_front import clus_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clus_req_if.sink    i_req,
    output t_queue_head o_head,
    input  logic        i_pop
);

    t_cmd              r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    t_cmd              cmd_in;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign i_req.ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push        = i_req.valid && i_req.ready;

    always_comb begin
        cmd_in.known     = (i_req.word.operation <= OP_READ);
        cmd_in.op        = t_op'(i_req.word.operation);
        cmd_in.index     = i_req.word.index;
        cmd_in.term      = i_req.word.term;
        cmd_in.data      = i_req.word.data;
        cmd_in.range_end = i_req.word.range_end;
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

@@ src/clus_back.sv @@
// Back end: log state, entry ring and the two-step execute sequencer.
`timescale 1ns / 1ps

module clus_back import clus_pkg::*; #(
    parameter int unsigned DEPTH     = 1024,
    parameter int unsigned DATA_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_head i_head,
    output logic        o_pop,
    clus_rsp_if.source  o_rsp
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned SW = AW + 1;

    t_back_state r_state, n_state;

    // log state
    logic [63:0] r_first, n_first;
    logic [63:0] r_last, n_last;
    logic        r_snap_valid, n_snap_valid;
    logic [63:0] r_snap_index, n_snap_index;
    logic [63:0] r_snap_term, n_snap_term;
    logic        r_nonempty, n_nonempty;
    logic [AW-1:0] r_base, n_base;  // ring slot of the first held entry

    // first step results
    logic [63:0] r_lo_off;
    logic [63:0] r_hi_off;
    logic [63:0] r_count;
    logic        r_snap_hit;
    logic        r_is_next;
    logic        r_le_first;
    logic        r_gt_next;
    logic [AW-1:0] r_slot;

    // entry ring
    logic [63:0]          r_mem_term [DEPTH];
    logic [DATA_BITS-1:0] r_mem_word [DEPTH];
    logic [63:0]          r_rd_term;
    logic [DATA_BITS-1:0] r_rd_word;

    logic          r_out_valid;
    t_rsp_word     r_out, n_rsp;

    t_cmd          cmd;
    logic [63:0]   off_now;
    logic [SW-1:0] slot_sum;
    logic [AW-1:0] slot_calc;
    logic          commit;
    logic          held;
    logic [63:0]   found_term;
    logic [SW-1:0] base_sum;
    logic [AW-1:0] base_adv;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;

    assign cmd = i_head.cmd;

    // slot of the addressed entry, by offset from the first held entry
    assign off_now   = cmd.index - r_first;
    assign slot_sum  = {1'b0, r_base} + SW'(off_now[AW-1:0]);
    assign slot_calc = (slot_sum >= SW'(DEPTH)) ? AW'(slot_sum - SW'(DEPTH))
                                                : slot_sum[AW-1:0];

    assign commit = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);
    assign o_pop  = commit;

    assign held       = (r_lo_off < r_count);
    assign found_term = r_snap_hit ? r_snap_term : r_rd_term;
    assign base_sum   = {1'b0, r_base} + SW'(r_lo_off[AW-1:0]) + SW'(1);
    assign base_adv   = (base_sum >= SW'(DEPTH)) ? AW'(base_sum - SW'(DEPTH))
                                                 : base_sum[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CALC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CALC: begin
                if (i_head.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state = S_CALC;
                end
            end
            default: n_state = S_CALC;
        endcase
    end

    // first step: offsets and compares against the current state
    always_ff @(posedge i_clk) begin
        if (r_state == S_CALC) begin
            r_lo_off   <= off_now;
            r_hi_off   <= cmd.range_end - r_first;
            r_count    <= r_last - r_first + 64'd1;
            r_snap_hit <= r_snap_valid && (r_snap_index == cmd.index);
            r_is_next  <= (cmd.index == r_last + 64'd1);
            r_le_first <= (cmd.index <= r_first);
            r_gt_next  <= (cmd.index > r_last + 64'd1);
            r_slot     <= slot_calc;
            r_rd_term  <= r_mem_term[slot_calc];
            r_rd_word  <= r_mem_word[slot_calc];
        end
    end

    // second step: decide, update the state and form the response word
    always_comb begin
        t_status st;
        logic [63:0] t_o;
        logic [63:0] d_o;

        st           = ST_MISS;
        t_o          = '0;
        d_o          = '0;
        n_first      = r_first;
        n_last       = r_last;
        n_snap_valid = r_snap_valid;
        n_snap_index = r_snap_index;
        n_snap_term  = r_snap_term;
        n_nonempty   = r_nonempty;
        n_base       = r_base;
        mem_we       = 1'b0;
        mem_waddr    = r_slot;

        if (cmd.known) begin
            unique case (cmd.op)
                OP_APPEND: begin
                    priority if (r_is_next) begin
                        if (r_count >= 64'(DEPTH)) begin
                            st = ST_DROP;
                        end else begin
                            st = ST_OK;
                        end
                    end else if (r_le_first) begin
                        st        = ST_OK;
                        n_first   = cmd.index;
                        n_base    = '0;
                        mem_waddr = '0;
                    end else if (r_gt_next) begin
                        st = ST_DROP;
                    end else begin
                        st = ST_OK;
                    end
                    if (st == ST_OK) begin
                        n_last     = cmd.index;
                        n_nonempty = 1'b1;
                        mem_we     = 1'b1;
                    end
                end
                OP_STABLE: begin
                    if (held && (found_term == cmd.term)) begin
                        st         = ST_OK;
                        n_first    = cmd.index + 64'd1;
                        n_base     = base_adv;
                        n_nonempty = (r_lo_off + 64'd1 != r_count);
                    end
                end
                OP_STABLE_SNAP: begin
                    if (r_snap_hit) begin
                        st           = ST_OK;
                        n_snap_valid = 1'b0;
                        n_snap_index = '0;
                        n_snap_term  = '0;
                    end
                end
                OP_RESTORE: begin
                    st           = ST_OK;
                    n_snap_valid = 1'b1;
                    n_snap_index = cmd.index;
                    n_snap_term  = cmd.term;
                    n_first      = cmd.index + 64'd1;
                    n_last       = cmd.index;
                    n_nonempty   = 1'b0;
                end
                OP_TERM: begin
                    if (r_snap_hit || held) begin
                        st  = ST_OK;
                        t_o = found_term;
                    end
                end
                OP_READ: begin
                    if (held && (r_hi_off > r_lo_off) && (r_hi_off <= r_count)) begin
                        st  = ST_OK;
                        t_o = r_rd_term;
                        d_o = 64'(r_rd_word);
                    end
                end
                default: st = ST_MISS;
            endcase
        end

        n_rsp.status             = st;
        n_rsp.term_out           = t_o;
        n_rsp.data_out           = d_o;
        n_rsp.has_first          = n_snap_valid;
        n_rsp.first_out          = n_snap_valid ? n_snap_index + 64'd1 : '0;
        n_rsp.has_last           = n_nonempty || n_snap_valid;
        n_rsp.last_out           = n_nonempty   ? n_last :
                                   n_snap_valid ? n_snap_index : '0;
        n_rsp.has_snapshot       = n_snap_valid;
        n_rsp.snapshot_index_out = n_snap_valid ? n_snap_index : '0;
        n_rsp.snapshot_term_out  = n_snap_valid ? n_snap_term : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first      <= 64'd1;
            r_last       <= '0;
            r_snap_valid <= 1'b0;
            r_snap_index <= '0;
            r_snap_term  <= '0;
            r_nonempty   <= 1'b0;
            r_base       <= '0;
        end else if (commit) begin
            r_first      <= n_first;
            r_last       <= n_last;
            r_snap_valid <= n_snap_valid;
            r_snap_index <= n_snap_index;
            r_snap_term  <= n_snap_term;
            r_nonempty   <= n_nonempty;
            r_base       <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit && mem_we) begin
            r_mem_term[mem_waddr] <= cmd.term;
            r_mem_word[mem_waddr] <= cmd.data[DATA_BITS-1:0];
        end
    end

    // output register: the next word may be worked on while this one waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out <= n_rsp;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.word  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> (r_count <= 64'(DEPTH)))
        else $error("held entry count exceeds ring depth");

    a_nonempty_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> (r_nonempty == (r_count != 64'd0)))
        else $error("non-empty flag disagrees with first/last indices");

    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_base} < SW'(DEPTH))
        else $error("ring base slot out of range");

    a_drop_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (n_rsp.status == ST_DROP)) |=> ($stable(r_first) && $stable(r_last)))
        else $error("dropped append changed the log bounds");

endmodule

@@ src/consensus_log_unstable_store.sv @@
// Top level of the unstable log store: queue front end and execute back end.
`timescale 1ns / 1ps

// Holds the unpersisted tail of a replicated log (up to DEPTH entries of term
// and data word) plus an optional pending snapshot, and answers one request
// word with one response word. A request is queued in a two-word front queue;
// the execute unit then works on it in two steps (one to form index offsets
// and read the entry ring, one to decide, update state and write the ring),
// and takes up the next request only once the last one has been decided,
// as the state update needs that ring read. The response sits in an output
// register, so the next request is already being worked on while it waits.
// Ring contents are only ever used for entries that were written, so there is
// no clearing pass after reset; the block takes requests straight away.
module consensus_log_unstable_store import clus_pkg::*; #(
    parameter int unsigned DEPTH     = 1024,
    parameter int unsigned DATA_BITS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    clus_req_if.sink   i_req,
    clus_rsp_if.source o_rsp
);

    t_queue_head head;
    logic        pop;

    clus_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_head  (head),
        .i_pop   (pop)
    );

    clus_back #(
        .DEPTH     (DEPTH),
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule
